FILE: sv/hvon_pkg.sv
// Package for the HTTP field value whitespace normaliser.
// Transaction types, parse phases, mode codes and character constants.
// No dependencies.
`default_nettype none

package hvon_pkg;

  localparam int unsigned MAX_PENDING_WS = 32;
  localparam int unsigned WS_IDX_W       = $clog2(MAX_PENDING_WS);
  localparam int unsigned WS_CNT_W       = $clog2(MAX_PENDING_WS + 1);

  localparam logic [WS_CNT_W-1:0] WS_CNT_MAX = WS_CNT_W'(MAX_PENDING_WS);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_TOKEN  = 3'd1;
  localparam logic [2:0] PH_QUOTE  = 3'd2;
  localparam logic [2:0] PH_AFTERQ = 3'd3;
  localparam logic [2:0] PH_DROP   = 3'd4;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_LIST   = 2'd1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       value_end;
    logic [1:0] mode;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_value;
    logic       error;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic ld_ws;
    logic ld_byte;
    logic ld_tail;
  } hvon_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dec_flush;
    logic dec_byte;
    logic dec_tail;
    logic q_byte;
    logic q_tail;
    logic ws_last;
    logic out_free;
  } hvon_sts_t;

endpackage

`default_nettype wire

FILE: sv/hvon_dp.sv
// Datapath of the whitespace normaliser: parse state, held whitespace,
// per-transaction decision and output register. Depends on hvon_pkg.
`default_nettype none

module hvon_dp import hvon_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_item_i,
  input  wire logic      out_stall_i,
  input  wire hvon_cmd_t cmd_i,
  output hvon_sts_t      sts_o,
  output logic           out_valid_o,
  output out_item_t      out_item_o
);

  logic [2:0]          phase_q, phase_d;
  logic [1:0]          mode_q;
  logic [WS_CNT_W-1:0] cnt_q, cnt_d;
  logic                first_q;
  logic [MAX_PENDING_WS-1:0] ws_kind_q;

  logic [7:0]          byte_q;
  logic                q_byte_q, q_tail_q, tail_err_q, last_q;
  logic [WS_CNT_W-1:0] flush_n_q, flush_idx_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic [1:0]          mode_eff;
  logic [2:0]          phase_eff, ph_n;
  logic [WS_CNT_W-1:0] cnt_eff;
  logic                ws, last, full;
  logic                hold, flush, put, err, clr, tail;
  logic                out_free;

  assign mode_eff  = first_q ? in_item_i.mode : mode_q;
  assign phase_eff = first_q ? PH_START : phase_q;
  assign cnt_eff   = first_q ? '0 : cnt_q;
  assign ws        = (in_item_i.in_byte == CH_SPACE) || (in_item_i.in_byte == CH_TAB);
  assign last      = in_item_i.value_end;
  assign full      = (cnt_eff >= WS_CNT_MAX);

  always_comb begin
    hold  = 1'b0;
    flush = 1'b0;
    put   = 1'b0;
    err   = 1'b0;
    clr   = 1'b0;
    ph_n  = phase_eff;
    if (phase_eff == PH_DROP) begin
      // rest of value dropped
    end else if (mode_eff == MODE_SINGLE) begin
      if (ws) begin
        if (phase_eff != PH_START) begin
          if (full) err = 1'b1;
          else      hold = 1'b1;
        end
      end else begin
        ph_n  = PH_TOKEN;
        flush = 1'b1;
        put   = 1'b1;
      end
    end else if (mode_eff == MODE_LIST) begin
      case (phase_eff)
        PH_START: begin
          if (!ws) begin
            put = 1'b1;
            if (in_item_i.in_byte == CH_QUOTE)      ph_n = PH_QUOTE;
            else if (in_item_i.in_byte != CH_COMMA) ph_n = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          if (ws) begin
            if (full) err = 1'b1;
            else      hold = 1'b1;
          end else if (in_item_i.in_byte == CH_COMMA) begin
            clr  = 1'b1;
            put  = 1'b1;
            ph_n = PH_START;
          end else begin
            flush = 1'b1;
            put   = 1'b1;
          end
        end
        PH_QUOTE: begin
          put = 1'b1;
          if (in_item_i.in_byte == CH_QUOTE) ph_n = PH_AFTERQ;
        end
        default: begin
          if (!ws) begin
            if (in_item_i.in_byte == CH_COMMA) begin
              put  = 1'b1;
              ph_n = PH_START;
            end else begin
              err = 1'b1;
            end
          end
        end
      endcase
    end else begin
      put = 1'b1;
    end

    // value ending inside a quoted element
    if (!err && last && (mode_eff == MODE_LIST) && (ph_n == PH_QUOTE)) err = 1'b1;
    if (err) ph_n = PH_DROP;

    tail = err || (last && !put);

    if (err || last || clr || flush) cnt_d = '0;
    else if (hold)                   cnt_d = cnt_eff + 1'b1;
    else                             cnt_d = cnt_eff;

    phase_d = last ? PH_START : ph_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      mode_q  <= MODE_SINGLE;
      cnt_q   <= '0;
      first_q <= 1'b1;
    end else if (cmd_i.accept) begin
      phase_q <= phase_d;
      mode_q  <= mode_eff;
      cnt_q   <= cnt_d;
      first_q <= last;
    end
  end

  // Held whitespace kinds, 1 = tab. Read only below the held count.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && hold) begin
      ws_kind_q[cnt_eff[WS_IDX_W-1:0]] <= (in_item_i.in_byte == CH_TAB);
    end
  end

  // Per-transaction job, held while its items go out
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q      <= in_item_i.in_byte;
      q_byte_q    <= put;
      q_tail_q    <= tail;
      tail_err_q  <= (ph_n == PH_DROP);
      last_q      <= last;
      flush_n_q   <= cnt_eff;
      flush_idx_q <= '0;
    end else if (cmd_i.ld_ws) begin
      flush_idx_q <= flush_idx_q + 1'b1;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ld_ws || cmd_i.ld_byte || cmd_i.ld_tail) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_ws) begin
      out_q.out_byte     <= ws_kind_q[flush_idx_q[WS_IDX_W-1:0]] ? CH_TAB : CH_SPACE;
      out_q.byte_valid   <= 1'b1;
      out_q.end_of_value <= 1'b0;
      out_q.error        <= 1'b0;
    end else if (cmd_i.ld_byte) begin
      out_q.out_byte     <= byte_q;
      out_q.byte_valid   <= 1'b1;
      out_q.end_of_value <= last_q && !q_tail_q;
      out_q.error        <= 1'b0;
    end else if (cmd_i.ld_tail) begin
      out_q.out_byte     <= '0;
      out_q.byte_valid   <= 1'b0;
      out_q.end_of_value <= last_q;
      out_q.error        <= tail_err_q;
    end
  end

  assign sts_o.dec_flush = flush && (cnt_eff != '0);
  assign sts_o.dec_byte  = put;
  assign sts_o.dec_tail  = tail;
  assign sts_o.q_byte    = q_byte_q;
  assign sts_o.q_tail    = q_tail_q;
  assign sts_o.ws_last   = (flush_idx_q == (flush_n_q - 1'b1));
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/hvon_ctrl.sv
// Controller of the whitespace normaliser: sequences held whitespace,
// the byte item and the tail item of each transaction. Depends on hvon_pkg.
`default_nettype none

module hvon_ctrl import hvon_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire hvon_sts_t sts_i,
  output hvon_cmd_t      cmd_o
);

  localparam logic [1:0] S_IN    = 2'd0;
  localparam logic [1:0] S_FLUSH = 2'd1;
  localparam logic [1:0] S_BYTE  = 2'd2;
  localparam logic [1:0] S_TAIL  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IN: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.dec_flush)     state_d = S_FLUSH;
          else if (sts_i.dec_byte) state_d = S_BYTE;
          else if (sts_i.dec_tail) state_d = S_TAIL;
        end
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.ld_ws = 1'b1;
          if (sts_i.ws_last) begin
            if (sts_i.q_byte)      state_d = S_BYTE;
            else if (sts_i.q_tail) state_d = S_TAIL;
            else                   state_d = S_IN;
          end
        end
      end
      S_BYTE: begin
        if (sts_i.out_free) begin
          cmd_o.ld_byte = 1'b1;
          state_d = sts_i.q_tail ? S_TAIL : S_IN;
        end
      end
      S_TAIL: begin
        if (sts_i.out_free) begin
          cmd_o.ld_tail = 1'b1;
          state_d = S_IN;
        end
      end
      default: state_d = S_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IN;
    else         state_q <= state_d;
  end

  assign in_stall_o = (state_q != S_IN);

endmodule

`default_nettype wire

FILE: sv/http_value_ows_normalizer_top.sv
// HTTP field value whitespace normaliser, top level.
// An accepted byte's job is registered; its result items then pass through the output register.
// Per byte: k held spaces/tabs flushed, then m items (0 to 2); the next byte waits for them.
// The controller sequences them through the output register; a stalled output holds them.
// Reset (rst_ni, async, low): element-start phase, no held whitespace, next byte opens a value.
`default_nettype none

module http_value_ows_normalizer_top import hvon_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  // input transactions
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  // result transactions
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_item_o
);

  // Controller and datapath talk only through these two bundles.
  hvon_cmd_t cmd;
  hvon_sts_t sts;

  // Controller: takes a byte when idle, then walks through flushed
  // whitespace, the byte itself and any error or end-only tail item.
  hvon_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: parse phase, held whitespace buffer, output register.
  hvon_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
